FILE: design/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg: shared types and constants of the palette fade engine
// Sizes, field widths, operation and status codes, register indexes and the
// controller state type.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int PALETTE_SIZE = 16;
  localparam int COMP_BITS    = 10;

  localparam int ADDR_W  = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam int CNT_W   = $clog2(PALETTE_SIZE + 1);
  localparam int ENTRY_W = 3 * COMP_BITS;
  localparam int PROD_W  = 2 * COMP_BITS;
  localparam int DIVD_W  = 32;
  localparam int CNT_DIV_W = $clog2(DIVD_W);

  localparam int OP_W    = 2;
  localparam int IDX_W   = 6;
  localparam int COLOR_W = 10;
  localparam int STAT_W  = 2;
  localparam int STEP_W  = 11;
  localparam int PCOUNT_W = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  localparam logic [STAT_W-1:0] ST_STEP   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FINISH = 2'd1;
  localparam logic [STAT_W-1:0] ST_ERROR  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FADE_DIR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PCOUNT   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_ERR_OUT,
    S_LEN_WAIT,
    S_EM_RD,
    S_EM_MUL,
    S_EM_DIV,
    S_EM_WAIT,
    S_EM_OUT,
    S_FIN_RD,
    S_FIN_OUT,
    S_MARK_OUT
  } pfe_state_t;

endpackage

FILE: design/pfe_in_if.sv
// ----------------------------------------------------------------------------
// pfe_in_if: input item channel
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
interface pfe_in_if;
  import pfe_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [IDX_W-1:0]   entry_index;
  logic [COLOR_W-1:0] red_in;
  logic [COLOR_W-1:0] green_in;
  logic [COLOR_W-1:0] blue_in;

  modport source (output valid, op, entry_index, red_in, green_in, blue_in,
                  input ready);
  modport sink (input valid, op, entry_index, red_in, green_in, blue_in,
                output ready);
endinterface

FILE: design/pfe_out_if.sv
// ----------------------------------------------------------------------------
// pfe_out_if: result channel
// Valid/ready channel carrying one palette color word.
// ----------------------------------------------------------------------------
interface pfe_out_if;
  import pfe_pkg::*;
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   out_index;
  logic [COLOR_W-1:0] red_out;
  logic [COLOR_W-1:0] green_out;
  logic [COLOR_W-1:0] blue_out;
  logic [STAT_W-1:0]  status;
  logic               last;

  modport source (output valid, out_index, red_out, green_out, blue_out, status, last,
                  input ready);
  modport sink (input valid, out_index, red_out, green_out, blue_out, status, last,
                output ready);
endinterface

FILE: design/pfe_cfg_if.sv
// ----------------------------------------------------------------------------
// pfe_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface pfe_cfg_if;
  import pfe_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/pfe_ram.sv
// ----------------------------------------------------------------------------
// pfe_ram: generic single-port-write, registered-read RAM
// One write port and one read port; read data is registered and appears in the cycle after re.
// ----------------------------------------------------------------------------
module pfe_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/pfe_div.sv
// ----------------------------------------------------------------------------
// pfe_div: radix-2 restoring divider
// Unsigned 32-bit dividend by a component-wide divisor, one quotient bit per
// cycle; done pulses with the quotient valid.
// ----------------------------------------------------------------------------
module pfe_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pfe_pkg::DIVD_W-1:0]    dividend,
  input  logic [pfe_pkg::COMP_BITS-1:0] divisor,
  output logic                          busy,
  output logic                          done,
  output logic [pfe_pkg::DIVD_W-1:0]    quotient
);
  import pfe_pkg::*;

  logic [CNT_DIV_W-1:0] cnt;
  logic [COMP_BITS-1:0] rem;
  logic [COMP_BITS-1:0] dvs;
  logic [COMP_BITS:0]   shifted;
  logic                 ge;

  // The remainder stays below the divisor, so it fits the component width.
  assign shifted = {rem, quotient[DIVD_W-1]};
  assign ge      = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_DIV_W'(DIVD_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
      cnt      <= '0;
    end else if (busy) begin
      rem      <= ge ? COMP_BITS'(shifted - {1'b0, dvs}) : shifted[COMP_BITS-1:0];
      quotient <= {quotient[DIVD_W-2:0], ge};
      cnt      <= cnt + 1'b1;
    end
  end

endmodule

FILE: design/palette_fade_engine_core.sv
// ----------------------------------------------------------------------------
// palette_fade_engine_core: linear palette fade engine
// Load and a tick without a step are taken in the idle state. Start scans each
// entry for the max component, runs the step-length divide, then one step.
// A step runs three divides per entry, one per channel, on the one shared
// divider. Items are taken one at a time.
// Reset (rst, synchronous) restores register defaults and idles the fade;
// palette contents are not cleared.
// ----------------------------------------------------------------------------
module palette_fade_engine_core (
  input logic       clk,
  input logic       rst,
  pfe_in_if.sink    items,
  pfe_out_if.source results,
  pfe_cfg_if.sink   cfg
);
  import pfe_pkg::*;

  pfe_state_t state, state_next;

  logic                  fade_dir;
  logic [31:0]           duration;
  logic [PCOUNT_W-1:0]   pcount;
  logic [COMP_BITS-1:0]  max_comp;
  logic [31:0]           step_len;
  logic [STEP_W-1:0]     step_num;
  logic [31:0]           ticks;
  logic                  active;
  logic [CNT_W-1:0]      p;
  logic [1:0]            ch;
  logic [PROD_W-1:0]     prod;
  logic [COMP_BITS-1:0]  col_r, col_g, col_b;

  logic                  accept;
  logic                  out_free;
  logic [CNT_W-1:0]      n_use;
  logic                  scan_done;
  logic                  last_entry;
  logic [31:0]           ticks_inc;
  logic                  step_over;
  logic [COMP_BITS-1:0]  num;
  logic [COMP_BITS-1:0]  comp_sel;

  logic                  ram_we, ram_re;
  logic [ENTRY_W-1:0]    ram_rdata;
  logic [COMP_BITS-1:0]  rd_r, rd_g, rd_b;

  logic                  div_start, div_busy, div_done;
  logic [DIVD_W-1:0]     div_dividend, div_q;

  assign accept   = items.valid && items.ready;
  assign out_free = !results.valid || results.ready;
  assign cfg.ready = 1'b1;

  assign n_use = (pcount > PCOUNT_W'(PALETTE_SIZE)) ? CNT_W'(PALETTE_SIZE)
                                                    : pcount[CNT_W-1:0];
  assign scan_done  = (p == n_use);
  assign last_entry = (p + 1'b1 == n_use);
  assign ticks_inc  = ticks + 32'd1;
  assign step_over  = (step_num + 1'b1) > {1'b0, max_comp};

  assign rd_r = ram_rdata[3*COMP_BITS-1:2*COMP_BITS];
  assign rd_g = ram_rdata[2*COMP_BITS-1:COMP_BITS];
  assign rd_b = ram_rdata[COMP_BITS-1:0];

  always_comb begin
    if (step_num > {1'b0, max_comp}) begin
      num = fade_dir ? max_comp : '0;
    end else begin
      num = fade_dir ? step_num[COMP_BITS-1:0] : max_comp - step_num[COMP_BITS-1:0];
    end
  end

  always_comb begin
    case (ch)
      2'd0:    comp_sel = rd_r;
      2'd1:    comp_sel = rd_g;
      default: comp_sel = rd_b;
    endcase
  end

  // Palette store: written by load words, read by the scan, emit and finish sequences.
  assign ram_we = accept && items.op == OP_LOAD &&
                  {1'b0, items.entry_index} < (IDX_W + 1)'(PALETTE_SIZE);

  pfe_ram #(.WIDTH(ENTRY_W), .DEPTH(PALETTE_SIZE)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (items.entry_index[ADDR_W-1:0]),
    .wdata ({items.red_in, items.green_in, items.blue_in}),
    .re    (ram_re),
    .raddr (p[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign div_dividend = (state == S_EM_DIV) ? DIVD_W'(prod) : duration;

  pfe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (max_comp),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    items.ready = 1'b0;
    ram_re      = 1'b0;
    div_start   = 1'b0;
    case (state)
      S_IDLE: begin
        items.ready = 1'b1;
        if (accept && items.op == OP_START) begin
          state_next = S_SCAN_RD;
        end else if (accept && items.op == OP_TICK && active &&
                     ticks_inc >= step_len) begin
          if (!step_over) begin
            state_next = S_EM_RD;
          end else if (!fade_dir && n_use != '0) begin
            state_next = S_FIN_RD;
          end else begin
            state_next = S_MARK_OUT;
          end
        end
      end
      S_SCAN_RD: begin
        if (!scan_done) begin
          ram_re     = 1'b1;
          state_next = S_SCAN_CMP;
        end else if (max_comp == '0) begin
          state_next = S_ERR_OUT;
        end else begin
          div_start  = 1'b1;
          state_next = S_LEN_WAIT;
        end
      end
      S_SCAN_CMP: state_next = S_SCAN_RD;
      S_ERR_OUT:  if (out_free) state_next = S_IDLE;
      S_LEN_WAIT: if (div_done) state_next = S_EM_RD;
      S_EM_RD: begin
        if (scan_done) begin
          state_next = S_IDLE;
        end else begin
          ram_re     = 1'b1;
          state_next = S_EM_MUL;
        end
      end
      S_EM_MUL: state_next = S_EM_DIV;
      S_EM_DIV: begin
        div_start  = 1'b1;
        state_next = S_EM_WAIT;
      end
      S_EM_WAIT: begin
        if (div_done) begin
          state_next = (ch == 2'd2) ? S_EM_OUT : S_EM_MUL;
        end
      end
      S_EM_OUT: begin
        if (out_free) begin
          state_next = last_entry ? S_IDLE : S_EM_RD;
        end
      end
      S_FIN_RD: begin
        ram_re     = 1'b1;
        state_next = S_FIN_OUT;
      end
      S_FIN_OUT: begin
        if (out_free) begin
          state_next = last_entry ? S_IDLE : S_FIN_RD;
        end
      end
      S_MARK_OUT: if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fade_dir <= 1'b0;
      duration <= 32'd1000;
      pcount   <= PCOUNT_W'(16);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_FADE_DIR: fade_dir <= cfg.data[0];
        REG_DURATION: duration <= cfg.data;
        REG_PCOUNT:   pcount   <= cfg.data[PCOUNT_W-1:0];
        default:      ;
      endcase
    end
  end

  // Fade state.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_comp <= '0;
      step_len <= '0;
      step_num <= '0;
      ticks    <= '0;
      active   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && items.op == OP_START) begin
            // The fade is off while the scan rebuilds the max component.
            max_comp <= '0;
            ticks    <= '0;
            active   <= 1'b0;
          end else if (accept && items.op == OP_TICK && active) begin
            if (ticks_inc < step_len) begin
              ticks <= ticks_inc;
            end else begin
              ticks    <= '0;
              step_num <= step_num + 1'b1;
              if (step_over) begin
                active <= 1'b0;
              end
            end
          end
        end
        S_SCAN_CMP: begin
          if (rd_r > max_comp && rd_r >= rd_g && rd_r >= rd_b) begin
            max_comp <= rd_r;
          end else if (rd_g > max_comp && rd_g >= rd_b) begin
            max_comp <= rd_g;
          end else if (rd_b > max_comp) begin
            max_comp <= rd_b;
          end
        end
        S_ERR_OUT: begin
          active   <= 1'b0;
          step_len <= '0;
          step_num <= '0;
        end
        S_LEN_WAIT: begin
          if (div_done) begin
            step_len <= div_q;
            step_num <= STEP_W'(1);
            active   <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Entry and channel sequencing, product and color staging.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE:     p <= '0;
      S_SCAN_CMP: p <= p + 1'b1;
      S_EM_RD:    ch <= 2'd0;
      S_EM_MUL:   prod <= comp_sel * num;
      S_EM_WAIT: begin
        if (div_done) begin
          case (ch)
            2'd0:    col_r <= div_q[COMP_BITS-1:0];
            2'd1:    col_g <= div_q[COMP_BITS-1:0];
            default: col_b <= div_q[COMP_BITS-1:0];
          endcase
          ch <= ch + 1'b1;
        end
      end
      S_LEN_WAIT: p <= '0;
      S_EM_OUT:   if (out_free) p <= p + 1'b1;
      S_FIN_OUT:  if (out_free) p <= p + 1'b1;
      default:    ;
    endcase
  end

  // Output register: the word waits here until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (out_free) begin
      results.valid <= (state == S_ERR_OUT) || (state == S_EM_OUT) ||
                       (state == S_FIN_OUT) || (state == S_MARK_OUT);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      case (state)
        S_EM_OUT: begin
          results.out_index <= IDX_W'(p);
          results.red_out   <= COLOR_W'(col_r);
          results.green_out <= COLOR_W'(col_g);
          results.blue_out  <= COLOR_W'(col_b);
          results.status    <= ST_STEP;
          results.last      <= last_entry;
        end
        S_FIN_OUT: begin
          results.out_index <= IDX_W'(p);
          results.red_out   <= COLOR_W'(rd_r);
          results.green_out <= COLOR_W'(rd_g);
          results.blue_out  <= COLOR_W'(rd_b);
          results.status    <= ST_FINISH;
          results.last      <= last_entry;
        end
        S_ERR_OUT, S_MARK_OUT: begin
          results.out_index <= '0;
          results.red_out   <= '0;
          results.green_out <= '0;
          results.blue_out  <= '0;
          results.status    <= (state == S_ERR_OUT) ? ST_ERROR : ST_FINISH;
          results.last      <= 1'b1;
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_active_max: assert property (@(posedge clk) disable iff (rst)
    active |-> max_comp != '0)
    else $error("fade active with zero max component");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_LEN_WAIT || state == S_EM_WAIT))
    else $error("divider finished outside a wait state");

  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !div_busy)
    else $error("divider busy while controller idle");
`endif

endmodule

FILE: tb/sv/pfe_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pfe_checker: result predictor and scoreboard of the palette fade engine
// Watches the command, configuration and color channels, keeps its own copy
// of the palette, registers and fade state, predicts every color word and
// compares each accepted one with the oldest prediction.
// ----------------------------------------------------------------------------
module pfe_checker
  import pfe_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  pfe_in_if         items,
  pfe_out_if        results,
  pfe_cfg_if        cfg,
  output int        errors,
  output int        pending,
  output int        colors_checked
);

  typedef struct packed {
    logic [IDX_W-1:0]   index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [STAT_W-1:0]  status;
    logic               last;
  } color_word_t;

  color_word_t color_queue[$];

  logic [COLOR_W-1:0] orig_red[PALETTE_SIZE];
  logic [COLOR_W-1:0] orig_green[PALETTE_SIZE];
  logic [COLOR_W-1:0] orig_blue[PALETTE_SIZE];

  logic              fade_in;
  logic [31:0]       duration;
  logic [PCOUNT_W-1:0] entry_count;
  logic [COLOR_W-1:0] max_comp;
  logic [31:0]       step_len;
  int unsigned       step_num;
  logic [31:0]       tick_count;
  logic              active;

  initial begin
    errors = 0;
    pending = 0;
    colors_checked = 0;
    for (int p = 0; p < PALETTE_SIZE; p++) begin
      orig_red[p] = '0;
      orig_green[p] = '0;
      orig_blue[p] = '0;
    end
  end

  function automatic int unsigned entries_used();
    return (entry_count > PALETTE_SIZE) ? PALETTE_SIZE : entry_count;
  endfunction

  function automatic logic [COLOR_W-1:0] scaled(logic [COLOR_W-1:0] c, int unsigned num);
    longint unsigned prod;
    prod = longint'(c) * num;
    return COLOR_W'(prod / max_comp);
  endfunction

  task automatic push_color(int unsigned idx, logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                            logic [COLOR_W-1:0] b, logic [STAT_W-1:0] st, logic lst);
    color_word_t w;
    w.index = IDX_W'(idx);
    w.red = r;
    w.green = g;
    w.blue = b;
    w.status = st;
    w.last = lst;
    color_queue.push_back(w);
  endtask

  task automatic emit_scaled_step();
    int unsigned n;
    int unsigned num;
    n = entries_used();
    if (step_num > max_comp) num = fade_in ? max_comp : 0;
    else num = fade_in ? step_num : max_comp - step_num;
    for (int unsigned p = 0; p < n; p++)
      push_color(p, scaled(orig_red[p], num), scaled(orig_green[p], num),
                 scaled(orig_blue[p], num), ST_STEP, p + 1 == n);
  endtask

  task automatic end_fade();
    int unsigned n;
    n = entries_used();
    active = 1'b0;
    if (fade_in || n == 0) begin
      push_color(0, '0, '0, '0, ST_FINISH, 1'b1);
    end else begin
      for (int unsigned p = 0; p < n; p++)
        push_color(p, orig_red[p], orig_green[p], orig_blue[p], ST_FINISH, p + 1 == n);
    end
  endtask

  task automatic apply_command();
    int unsigned n;
    logic [COLOR_W-1:0] m;
    case (items.op)
      OP_LOAD: begin
        if (items.entry_index < PALETTE_SIZE) begin
          orig_red[items.entry_index[ADDR_W-1:0]] = items.red_in;
          orig_green[items.entry_index[ADDR_W-1:0]] = items.green_in;
          orig_blue[items.entry_index[ADDR_W-1:0]] = items.blue_in;
        end
      end
      OP_START: begin
        n = entries_used();
        m = '0;
        for (int unsigned p = 0; p < n; p++) begin
          if (orig_red[p] > m) m = orig_red[p];
          if (orig_green[p] > m) m = orig_green[p];
          if (orig_blue[p] > m) m = orig_blue[p];
        end
        max_comp = m;
        tick_count = '0;
        if (m == 0) begin
          active = 1'b0;
          step_len = '0;
          step_num = 0;
          push_color(0, '0, '0, '0, ST_ERROR, 1'b1);
        end else begin
          step_len = duration / m;
          step_num = 1;
          active = 1'b1;
          emit_scaled_step();
        end
      end
      OP_TICK: begin
        if (active && max_comp != 0) begin
          tick_count++;
          if (tick_count >= step_len) begin
            tick_count = '0;
            step_num++;
            if (step_num > max_comp) end_fade();
            else emit_scaled_step();
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report(string field, int unsigned want, int unsigned got);
    $display("mismatch at %0t: %s expected %0d got %0d", $realtime, field, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    color_word_t w;
    if (rst) begin
      fade_in = 1'b0;
      duration = 32'd1000;
      entry_count = PCOUNT_W'(16);
      max_comp = '0;
      step_len = '0;
      step_num = 0;
      tick_count = '0;
      active = 1'b0;
      color_queue.delete();
    end else begin
      if (results.valid && results.ready) begin
        colors_checked++;
        if (color_queue.size() == 0) begin
          report("unexpected word, index", 0, results.out_index);
        end else begin
          w = color_queue.pop_front();
          if (results.out_index !== w.index) report("out_index", w.index, results.out_index);
          if (results.red_out !== w.red) report("red_out", w.red, results.red_out);
          if (results.green_out !== w.green) report("green_out", w.green, results.green_out);
          if (results.blue_out !== w.blue) report("blue_out", w.blue, results.blue_out);
          if (results.status !== w.status) report("status", w.status, results.status);
          if (results.last !== w.last) report("last", w.last, results.last);
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_FADE_DIR: fade_in = cfg.data[0];
          REG_DURATION: duration = cfg.data;
          REG_PCOUNT:   entry_count = cfg.data[PCOUNT_W-1:0];
          default: ;
        endcase
      end
      if (items.valid && items.ready) apply_command();
    end
    pending = color_queue.size();
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the palette fade engine
// Loads the palette, runs fades in both directions under several register
// settings with random command streams, random stalls on both channels and
// one long hold on the color output; the checker judges every word.
// ----------------------------------------------------------------------------
module testbench;
  import pfe_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pfe_in_if  items();
  pfe_out_if results();
  pfe_cfg_if cfg();

  int errors;
  int pending;
  int colors_checked;
  int words_sent = 0;
  int send_idle = 12;
  int recv_idle = 75;
  bit hold_rx = 1'b0;

  palette_fade_engine_core u_top (
    .clk(clk), .rst(rst), .items(items), .results(results), .cfg(cfg)
  );

  pfe_checker u_checker (
    .clk(clk), .rst(rst), .items(items), .results(results), .cfg(cfg),
    .errors(errors), .pending(pending), .colors_checked(colors_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk)
    results.ready <= !rst && !hold_rx && ($urandom_range(99) >= recv_idle);

  initial begin
    #50ms;
    $display("timeout");
    $display("simulation failed");
    $finish;
  end

  task automatic send_word(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                           logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                           logic [COLOR_W-1:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      items.valid <= 1'b0;
      @(negedge clk);
    end
    items.valid <= 1'b1;
    items.op <= op;
    items.entry_index <= idx;
    items.red_in <= r;
    items.green_in <= g;
    items.blue_in <= b;
    @(posedge clk);
    while (!items.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    items.valid <= 1'b0;
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // A load or a tick without a step leaves no word behind, so wait on past the empty queue to let the engine settle.
  task automatic wait_idle();
    @(negedge clk);
    items.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic run_phase(bit dir, logic [31:0] dur, int count, int n, bit dim,
                           bit squeeze);
    int roll;
    logic [OP_W-1:0] op;
    logic [IDX_W-1:0] idx;
    logic [COLOR_W-1:0] r, g, b;
    wait_idle();
    write_reg(REG_FADE_DIR, dir);
    write_reg(REG_DURATION, dur);
    write_reg(REG_PCOUNT, count);
    if (squeeze) begin
      fork
        begin
          hold_rx = 1'b1;
          repeat (400) @(posedge clk);
          hold_rx = 1'b0;
        end
      join_none
    end
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      idx = $urandom;
      r = $urandom;
      g = $urandom;
      b = $urandom;
      if (i == 0 || (roll >= 20 && roll < 28)) op = OP_START;
      else if (roll < 20) begin
        op = OP_LOAD;
        idx = ($urandom_range(9) == 0) ? $urandom_range(63, 16) : $urandom_range(15);
        if (dim) begin
          r = $urandom_range(3);
          g = $urandom_range(3);
          b = $urandom_range(3);
        end
      end else if (roll < 97) op = OP_TICK;
      else op = OP_UNUSED;
      send_word(op, idx, r, g, b);
    end
  endtask

  initial begin
    items.valid = 1'b0;
    items.op = OP_TICK;
    items.entry_index = '0;
    items.red_in = '0;
    items.green_in = '0;
    items.blue_in = '0;
    cfg.valid = 1'b0;
    cfg.index = REG_FADE_DIR;
    cfg.data = '0;
    results.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: two entries in use with max 3 and a step on every tick.
    write_reg(REG_FADE_DIR, 0);
    write_reg(REG_DURATION, 1);
    write_reg(REG_PCOUNT, 2);
    send_word(OP_TICK, 0, 0, 0, 0);
    for (int p = 0; p < PALETTE_SIZE; p++) begin
      case (p)
        0: send_word(OP_LOAD, p, 1, 2, 3);
        1: send_word(OP_LOAD, p, 3, 0, 1);
        2: send_word(OP_LOAD, p, 10'h3FF, 10'h3FF, 10'h3FF);
        3: send_word(OP_LOAD, p, 10'h155, 10'h2AA, 0);
        default: send_word(OP_LOAD, p, $urandom, $urandom, $urandom);
      endcase
    end
    send_word(OP_LOAD, 63, 10'h3FF, 10'h3FF, 10'h3FF);
    send_word(OP_UNUSED, 6'h3F, 10'h3FF, 10'h3FF, 10'h3FF);
    send_word(OP_START, 0, 0, 0, 0);
    repeat (4) send_word(OP_TICK, 0, 0, 0, 0);
    send_word(OP_START, 0, 0, 0, 0);
    send_word(OP_TICK, 0, 0, 0, 0);
    send_word(OP_START, 0, 0, 0, 0);
    send_word(OP_LOAD, 1, 2, 2, 2);
    send_word(OP_TICK, 0, 0, 0, 0);

    run_phase(1, 5, 3, 30, 1, 0);
    send_idle = 75;
    recv_idle = 12;
    run_phase(0, 32'hFFFF_FFFF, 64, 30, 0, 0);
    run_phase(1, 1, 0, 10, 1, 0);
    send_idle = 0;
    recv_idle = 0;
    run_phase(0, 2, 127, 40, 1, 1);
    run_phase(1, 8, 5, 30, 1, 0);

    wait_idle();
    repeat (200) @(posedge clk);
    $display("sent %0d command words over six register settings, both fade directions,",
             words_sent);
    $display("checked %0d color words including a long output hold", colors_checked);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: palette_fade_engine_core.f
design/pfe_pkg.sv
design/pfe_in_if.sv
design/pfe_out_if.sv
design/pfe_cfg_if.sv
design/pfe_ram.sv
design/pfe_div.sv
design/palette_fade_engine_core.sv
tb/sv/pfe_checker.sv
tb/sv/testbench.sv
